// ===== rtl/weighted_three_level_rr_scheduler_assert.svh =====
// assertion macros shared by the scheduler modules
`ifndef WEIGHTED_THREE_LEVEL_RR_SCHEDULER_ASSERT_SVH
`define WEIGHTED_THREE_LEVEL_RR_SCHEDULER_ASSERT_SVH

// checked only outside reset
`define WTRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in reset too
`define WTRR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wtrr_pkg.sv =====
`default_nettype none
package wtrr_pkg;

  localparam int QDEPTH  = 16;
  localparam int IDX_W   = $clog2(QDEPTH);
  localparam int FILL_W  = $clog2(QDEPTH + 1);
  localparam int NQ      = 3;
  localparam int Q_W     = 2;
  localparam int ADDR_W  = $clog2(NQ * QDEPTH);
  localparam int ID_BITS = 8;
  localparam int CFG_W   = 6;

  localparam logic [CFG_W-1:0] HIGH_END_RST  = 6'd9;
  localparam logic [CFG_W-1:0] MED_END_RST   = 6'd15;
  localparam logic [CFG_W-1:0] CYCLE_LEN_RST = 6'd19;

  localparam logic [1:0] CFG_HIGH_END  = 2'd0;
  localparam logic [1:0] CFG_MED_END   = 2'd1;
  localparam logic [1:0] CFG_CYCLE_LEN = 2'd2;

  localparam logic [1:0] PRIO_HIGH = 2'b11;
  localparam logic [1:0] PRIO_MED  = 2'b00;

  localparam logic [Q_W-1:0] Q_HIGH = 2'd0;
  localparam logic [Q_W-1:0] Q_MED  = 2'd1;
  localparam logic [Q_W-1:0] Q_LOW  = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_SCHED  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_IDLE     = 2'd1,
    OUT_FULL     = 2'd2,
    OUT_NOTFOUND = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_END_Q,
    ST_TAIL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic         ready;
    logic [ID_BITS-1:0] id;
  } slot_t;

  typedef struct packed {
    logic latch;
    logic rd;
    logic chk;
    logic next_q;
    logic tail;
    logic fin;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic scan_end;
    logic hit;
    logic last_q;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/wtrr_ctrl.sv =====
`default_nettype none
module wtrr_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               out_stall,
  input  wtrr_pkg::sts_t    sts,
  output wtrr_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import wtrr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_DISP;
      ST_DISP:    state_nxt = (sts.req == REQ_ADD) ? ST_FIN : ST_SCAN_RD;
      ST_SCAN_RD: state_nxt = sts.scan_end ? ST_END_Q : ST_SCAN_CK;
      ST_SCAN_CK: state_nxt = ST_SCAN_RD;
      ST_END_Q: begin
        if (sts.req != REQ_SCHED) state_nxt = ST_FIN;
        else if (sts.hit) state_nxt = ST_TAIL;
        else if (sts.last_q) state_nxt = ST_FIN;
        else state_nxt = ST_SCAN_RD;
      end
      ST_TAIL:    state_nxt = ST_FIN;
      ST_FIN:     state_nxt = ST_OUT;
      ST_OUT:     if (!out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = (state_r != ST_IDLE);
    out_valid  = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE:    cmd.latch = in_valid;
      ST_SCAN_RD: cmd.rd = !sts.scan_end;
      ST_SCAN_CK: cmd.chk = 1'b1;
      ST_END_Q:   cmd.next_q = (sts.req == REQ_SCHED) && !sts.hit && !sts.last_q;
      ST_TAIL:    cmd.tail = 1'b1;
      ST_FIN:     cmd.fin = 1'b1;
      default:    cmd = '0;
    endcase
  end

`include "weighted_three_level_rr_scheduler_assert.svh"
  `WTRR_ASSERT(a_out_blocks_in, out_valid |-> in_stall, "input taken while word pending")
  `WTRR_ASSERT(a_out_done, (out_valid && !out_stall) |=> (state_r == ST_IDLE), "no return to idle")
  `WTRR_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE), "reset not idle")

endmodule
`default_nettype wire

// ===== rtl/wtrr_dp.sv =====
`default_nettype none
module wtrr_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wtrr_pkg::cmd_t               cmd,
  output wtrr_pkg::sts_t               sts,
  input  wire  [1:0]                   in_req_type,
  input  wire  [wtrr_pkg::ID_BITS-1:0] in_task_id,
  input  wire  signed [1:0]            in_prio_level,
  input  wire                          in_is_ready,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [wtrr_pkg::CFG_W-1:0]   cfg_data,
  output logic [wtrr_pkg::ID_BITS-1:0] out_chosen_id,
  output logic [1:0]                   out_outcome
);
  import wtrr_pkg::*;

  slot_t mem [NQ*QDEPTH];
  slot_t rdata_r;

  logic [CFG_W-1:0]  high_end_r, med_end_r, cycle_len_r, cnt_r;
  logic [FILL_W-1:0] fill_r [NQ];
  logic [FILL_W-1:0] i_r;
  logic [Q_W-1:0]    q_r, start_q;
  logic [1:0]        k_r;
  logic              hit_r;
  slot_t             saved_r;
  req_t              req_r;
  logic [ID_BITS-1:0] id_r;
  logic              rdy_r;

  logic [FILL_W-1:0] fill_q;
  logic              match;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  slot_t             wr_data;
  logic [CFG_W:0]    cnt_inc;

  assign fill_q  = fill_r[q_r];
  assign match   = (rdata_r.id == id_r);
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  assign sts.req      = req_r;
  assign sts.scan_end = (i_r == fill_q);
  assign sts.hit      = hit_r;
  assign sts.last_q   = (k_r == 2'd2);

  always_comb begin
    if (cnt_r < high_end_r) start_q = Q_HIGH;
    else if (cnt_r < med_end_r) start_q = Q_MED;
    else start_q = Q_LOW;
  end

  // memory write port: shift down, in-place status, tail move, append
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = IDX_W'(i_r - 1'b1);
    wr_data = rdata_r;
    if (cmd.chk) begin
      case (req_r)
        REQ_STATUS: begin
          wr_en   = match;
          wr_idx  = i_r[IDX_W-1:0];
          wr_data = '{ready: rdy_r, id: rdata_r.id};
        end
        REQ_REMOVE, REQ_SCHED: wr_en = hit_r;
        default: wr_en = 1'b0;
      endcase
    end else if (cmd.tail) begin
      wr_en   = 1'b1;
      wr_idx  = IDX_W'(fill_q - 1'b1);
      wr_data = saved_r;
    end else if (cmd.fin && req_r == REQ_ADD) begin
      wr_en   = (fill_q != FILL_W'(QDEPTH));
      wr_idx  = fill_q[IDX_W-1:0];
      wr_data = '{ready: rdy_r, id: id_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[{q_r, wr_idx}] <= wr_data;
    if (cmd.rd) rdata_r <= mem[{q_r, i_r[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_end_r  <= HIGH_END_RST;
      med_end_r   <= MED_END_RST;
      cycle_len_r <= CYCLE_LEN_RST;
      cnt_r       <= '0;
      for (int n = 0; n < NQ; n++) fill_r[n] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HIGH_END:  high_end_r  <= cfg_data;
          CFG_MED_END:   med_end_r   <= cfg_data;
          CFG_CYCLE_LEN: cycle_len_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.fin) begin
        case (req_r)
          REQ_ADD:
            if (fill_q != FILL_W'(QDEPTH)) fill_r[q_r] <= fill_q + 1'b1;
          REQ_REMOVE:
            if (hit_r) fill_r[q_r] <= fill_q - 1'b1;
          REQ_SCHED:
            cnt_r <= (cnt_inc >= {1'b0, cycle_len_r}) ? '0 : cnt_inc[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= req_t'(in_req_type);
      id_r  <= in_task_id;
      rdy_r <= in_is_ready;
      i_r   <= '0;
      k_r   <= '0;
      hit_r <= 1'b0;
      if (req_t'(in_req_type) == REQ_SCHED) q_r <= start_q;
      else if (in_prio_level == PRIO_HIGH) q_r <= Q_HIGH;
      else if (in_prio_level == PRIO_MED) q_r <= Q_MED;
      else q_r <= Q_LOW;
    end
    if (cmd.chk) begin
      i_r <= i_r + 1'b1;
      case (req_r)
        REQ_STATUS: if (match) hit_r <= 1'b1;
        REQ_REMOVE: if (match) hit_r <= 1'b1;
        REQ_SCHED:
          if (!hit_r && rdata_r.ready) begin
            hit_r   <= 1'b1;
            saved_r <= rdata_r;
          end
        default: ;
      endcase
    end
    if (cmd.next_q) begin
      q_r <= (q_r == Q_LOW) ? Q_HIGH : q_r + 1'b1;
      k_r <= k_r + 1'b1;
      i_r <= '0;
    end
    if (cmd.fin) begin
      out_chosen_id <= '0;
      case (req_r)
        REQ_ADD: out_outcome <= (fill_q == FILL_W'(QDEPTH)) ? OUT_FULL : OUT_OK;
        REQ_SCHED: begin
          out_outcome <= hit_r ? OUT_OK : OUT_IDLE;
          if (hit_r) out_chosen_id <= saved_r.id;
        end
        default: out_outcome <= hit_r ? OUT_OK : OUT_NOTFOUND;
      endcase
    end
  end

`include "weighted_three_level_rr_scheduler_assert.svh"
  `WTRR_ASSERT(a_fill_hi, fill_r[Q_HIGH] <= FILL_W'(QDEPTH), "high queue overfilled")
  `WTRR_ASSERT(a_fill_lo, (fill_r[Q_MED] <= FILL_W'(QDEPTH)) && (fill_r[Q_LOW] <= FILL_W'(QDEPTH)), "queue overfilled")
  `WTRR_ASSERT(a_tail_hit, cmd.tail |-> (hit_r && fill_q != '0), "tail move without pick")

endmodule
`default_nettype wire

// ===== rtl/weighted_three_level_rr_scheduler.sv =====
`default_nettype none
// Three-queue weighted round-robin task scheduler. One request word in, one result word out;
// requests are handled one at a time. An add appends the task to its queue directly; a remove
// or status update walks the queue entry by entry through one memory read port, reading and
// then checking each entry; a schedule searches the queues in turn in the same way, from the
// start queue that the slot counter selects, and a picked task is moved to the tail of its
// queue. Output stalls hold the result word until it is taken.
// Registers high_end, med_end and cycle_len are to be written through the cfg port only
// while no request is in flight; the block itself does not enforce it.
module weighted_three_level_rr_scheduler (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   in_req_type,
  input  wire  [wtrr_pkg::ID_BITS-1:0] in_task_id,
  input  wire  signed [1:0]            in_prio_level,
  input  wire                          in_is_ready,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [wtrr_pkg::ID_BITS-1:0] out_chosen_id,
  output logic [1:0]                   out_outcome,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [1:0]                   cfg_index,
  input  wire  [wtrr_pkg::CFG_W-1:0]   cfg_data
);
  import wtrr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  wtrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  wtrr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_req_type),
    .in_task_id    (in_task_id),
    .in_prio_level (in_prio_level),
    .in_is_ready   (in_is_ready),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_chosen_id (out_chosen_id),
    .out_outcome   (out_outcome)
  );

endmodule
`default_nettype wire

// ===== sim/weighted_three_level_rr_scheduler_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module weighted_three_level_rr_scheduler_tb;
  import wtrr_pkg::*;

  typedef struct packed {
    req_t       req;
    logic [7:0] id;
    logic [1:0] prio;
    logic       rdy;
  } sched_req_t;

  typedef struct packed {
    logic [7:0] id;
    outcome_t   outcome;
  } sched_res_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire  in_stall;
  logic [1:0] in_req_type = '0;
  logic [7:0] in_task_id = '0;
  logic signed [1:0] in_prio_level = '0;
  logic in_is_ready = 1'b0;
  wire  out_valid;
  logic out_stall = 1'b0;
  wire  [7:0] out_chosen_id;
  wire  [1:0] out_outcome;
  logic cfg_valid = 1'b0;
  wire  cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;

  weighted_three_level_rr_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_task_id(in_task_id), .in_prio_level(in_prio_level), .in_is_ready(in_is_ready),
    .out_valid(out_valid), .out_stall(out_stall), .out_chosen_id(out_chosen_id),
    .out_outcome(out_outcome),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler model state
  slot_t      qmem [3][QDEPTH];
  int         qfill [3];
  logic [5:0] slot_cnt;
  logic [5:0] high_end_r, med_end_r, cycle_len_r;

  sched_req_t pending_reqs[$];
  sched_res_t expected_res[$];
  int  errors = 0;
  bit  drv_hold = 1'b0;
  int  burst_left = 0, gap_left = 0;
  int  watchdog = 0;
  int  stall_phase = 0;

  function automatic int queue_of(logic [1:0] p);
    if (p == PRIO_HIGH) return 0;
    if (p == PRIO_MED) return 1;
    return 2;
  endfunction

  function automatic void drop_entry(int q, int pos);
    for (int i = pos; i + 1 < qfill[q]; i++) qmem[q][i] = qmem[q][i+1];
    qfill[q]--;
  endfunction

  function automatic sched_res_t predict_sched(sched_req_t r);
    sched_res_t res;
    int q, start, qq;
    bit hit;
    slot_t s;
    res.id = '0;
    res.outcome = OUT_OK;
    q = queue_of(r.prio);
    hit = 1'b0;
    case (r.req)
      REQ_ADD: begin
        if (qfill[q] >= QDEPTH) res.outcome = OUT_FULL;
        else begin
          qmem[q][qfill[q]] = {r.rdy, r.id};
          qfill[q]++;
        end
      end
      REQ_REMOVE: begin
        for (int i = 0; i < qfill[q] && !hit; i++)
          if (qmem[q][i].id == r.id) begin
            drop_entry(q, i);
            hit = 1'b1;
          end
        if (!hit) res.outcome = OUT_NOTFOUND;
      end
      REQ_STATUS: begin
        for (int i = 0; i < qfill[q]; i++)
          if (qmem[q][i].id == r.id) begin
            qmem[q][i].ready = r.rdy;
            hit = 1'b1;
          end
        if (!hit) res.outcome = OUT_NOTFOUND;
      end
      default: begin
        if (slot_cnt < high_end_r) start = 0;
        else if (slot_cnt < med_end_r) start = 1;
        else start = 2;
        for (int k = 0; k < 3 && !hit; k++) begin
          qq = (start + k) % 3;
          for (int i = 0; i < qfill[qq] && !hit; i++)
            if (qmem[qq][i].ready) begin
              s = qmem[qq][i];
              drop_entry(qq, i);
              qmem[qq][qfill[qq]] = s;
              qfill[qq]++;
              res.id = s.id;
              hit = 1'b1;
            end
        end
        if (!hit) res.outcome = OUT_IDLE;
        slot_cnt = ({26'd0, slot_cnt} + 1 >= {26'd0, cycle_len_r}) ? 6'd0 : slot_cnt + 6'd1;
      end
    endcase
    return res;
  endfunction

  // driver: bursts with gaps, holds payload while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_res.push_back(predict_sched({req_t'(in_req_type), in_task_id,
                                              in_prio_level, in_is_ready}));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !drv_hold) begin
          sched_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= r.req;
          in_task_id <= r.id;
          in_prio_level <= r.prio;
          in_is_ready <= r.rdy;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 400) % 3 == 0) out_stall <= 1'b0;
      else if ((stall_phase / 400) % 3 == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= (stall_phase % 7) < 4;
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected word chosen_id=%0d outcome=%0d",
                   $time, out_chosen_id, out_outcome);
          errors++;
        end else begin
          sched_res_t e;
          e = expected_res.pop_front();
          if (out_chosen_id !== e.id) begin
            $display("%0t: chosen_id mismatch expected %0d actual %0d",
                     $time, e.id, out_chosen_id);
            errors++;
          end
          if (out_outcome !== e.outcome) begin
            $display("%0t: outcome mismatch expected %0d actual %0d",
                     $time, e.outcome, out_outcome);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic void add_req(req_t rq, logic [7:0] id, logic [1:0] p, logic rdy);
    pending_reqs.push_back({rq, id, p, rdy});
  endfunction

  function automatic logic [1:0] rand_prio();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HIGH_END:  high_end_r = val;
      CFG_MED_END:   med_end_r = val;
      default:       cycle_len_r = val;
    endcase
    @(posedge clk);
  endtask

  // random phase: mostly adds/schedules on a small id space so hits are common
  task automatic random_phase(int n);
    int sel;
    logic [7:0] id;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (sel < 30) add_req(REQ_ADD, id, rand_prio(), 1'($urandom));
      else if (sel < 45) add_req(REQ_REMOVE, id, rand_prio(), 1'($urandom));
      else if (sel < 65) add_req(REQ_STATUS, id, rand_prio(), 1'($urandom));
      else add_req(REQ_SCHED, 8'($urandom), rand_prio(), 1'($urandom));
    end
  endtask

  initial begin
    for (int q = 0; q < 3; q++) qfill[q] = 0;
    slot_cnt = '0;
    high_end_r = HIGH_END_RST;
    med_end_r = MED_END_RST;
    cycle_len_r = CYCLE_LEN_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty schedule, extremes, all levels, full queue, not found
    add_req(REQ_SCHED, 8'h00, 2'b00, 1'b0);
    add_req(REQ_REMOVE, 8'hff, 2'b11, 1'b1);
    add_req(REQ_STATUS, 8'h00, 2'b00, 1'b1);
    add_req(REQ_ADD, 8'hff, 2'b11, 1'b1);
    add_req(REQ_ADD, 8'h00, 2'b00, 1'b0);
    add_req(REQ_ADD, 8'h55, 2'b01, 1'b1);
    add_req(REQ_ADD, 8'haa, 2'b10, 1'b1);
    add_req(REQ_ADD, 8'h55, 2'b01, 1'b0);
    add_req(REQ_STATUS, 8'h55, 2'b01, 1'b1);
    add_req(REQ_STATUS, 8'h00, 2'b00, 1'b1);
    add_req(REQ_SCHED, 8'h00, 2'b00, 1'b0);
    add_req(REQ_SCHED, 8'hff, 2'b11, 1'b1);
    add_req(REQ_REMOVE, 8'h55, 2'b01, 1'b0);
    add_req(REQ_REMOVE, 8'haa, 2'b10, 1'b0);
    add_req(REQ_STATUS, 8'h12, 2'b10, 1'b0);
    for (int i = 0; i < 17; i++) add_req(REQ_ADD, 8'(i), 2'b11, 1'(i));
    wait_drained();

    write_reg(CFG_HIGH_END, 6'd1);
    write_reg(CFG_MED_END, 6'd2);
    write_reg(CFG_CYCLE_LEN, 6'd3);
    random_phase(400);
    // sender holds off until every result is back
    drv_hold = 1'b1;
    while (in_valid || expected_res.size() > 0) @(posedge clk);
    drv_hold = 1'b0;
    wait_drained();

    write_reg(CFG_HIGH_END, 6'd63);
    write_reg(CFG_MED_END, 6'd63);
    write_reg(CFG_CYCLE_LEN, 6'd63);
    random_phase(400);
    wait_drained();

    // med_end below high_end, then a short cycle below the counter
    write_reg(CFG_HIGH_END, 6'd20);
    write_reg(CFG_MED_END, 6'd5);
    write_reg(CFG_CYCLE_LEN, 6'd1);
    random_phase(400);
    wait_drained();

    write_reg(CFG_HIGH_END, 6'($urandom_range(1, 63)));
    write_reg(CFG_MED_END, 6'($urandom_range(1, 63)));
    write_reg(CFG_CYCLE_LEN, 6'($urandom_range(1, 63)));
    random_phase(400);
    wait_drained();

    if (errors == 0 && expected_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== weighted_three_level_rr_scheduler.f =====
+incdir+rtl
rtl/wtrr_pkg.sv
rtl/wtrr_ctrl.sv
rtl/wtrr_dp.sv
rtl/weighted_three_level_rr_scheduler.sv
sim/weighted_three_level_rr_scheduler_tb.sv
